@@ design/jsu_pkg.sv @@
// Shared types, constants and helper functions for the JSON string unescaper.
// Used by jsu_decode, jsu_outbuf and the top level json_string_unescape_utf8_core.
package jsu_pkg;

   localparam int MAX_CAPACITY_DEFAULT = 4096;
   localparam logic [12:0] CAPACITY_RESET = 13'd4096;

   // Closing status codes
   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_BAD_ESCAPE    = 3'd1,
      STATUS_NUL           = 3'd2,
      STATUS_TOO_LONG      = 3'd3,
      STATUS_BAD_SURROGATE = 3'd4,
      STATUS_TRUNCATED     = 3'd5
   } status_type;

   // Characters that steer the escape decode
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_U      = 8'h75;

   localparam logic [7:0] CTRL_BS  = 8'h08;
   localparam logic [7:0] CTRL_FF  = 8'h0C;
   localparam logic [7:0] CTRL_LF  = 8'h0A;
   localparam logic [7:0] CTRL_CR  = 8'h0D;
   localparam logic [7:0] CTRL_TAB = 8'h09;

   // Surrogate ranges and supplementary plane offset
   localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
   localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE    = 21'h10000;

   // UTF-8 lead and continuation markers
   localparam logic [7:0] LEAD2 = 8'hC0;
   localparam logic [7:0] LEAD3 = 8'hE0;
   localparam logic [7:0] LEAD4 = 8'hF0;
   localparam logic [7:0] CONT  = 8'h80;

   typedef struct packed {
      logic [2:0]      len;
      logic [3:0][7:0] bytes;
   } utf8_type;

   // Results caused by one input item: up to four data bytes, then a status at the end of a string
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      nbytes;
      logic            final_res;
      status_type      status;
      logic [11:0]     length;
   } group_type;

   // Bit 4 set means the byte is not a hex digit
   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      logic [4:0] r;
      begin
         r = 5'h10;
         if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b0, 4'(b - 8'h30)};
         end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b0, 4'(b - 8'h57)};
         end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b0, 4'(b - 8'h37)};
         end
         return r;
      end
   endfunction

   function automatic utf8_type utf8_encode(input logic [20:0] code);
      utf8_type r;
      begin
         r = '0;
         if (code < 21'h80) begin
            r.len      = 3'd1;
            r.bytes[0] = code[7:0];
         end else if (code < 21'h800) begin
            r.len      = 3'd2;
            r.bytes[0] = LEAD2 | {3'b000, code[10:6]};
            r.bytes[1] = CONT | {2'b00, code[5:0]};
         end else if (code < SUPP_BASE) begin
            r.len      = 3'd3;
            r.bytes[0] = LEAD3 | {4'b0000, code[15:12]};
            r.bytes[1] = CONT | {2'b00, code[11:6]};
            r.bytes[2] = CONT | {2'b00, code[5:0]};
         end else begin
            r.len      = 3'd4;
            r.bytes[0] = LEAD4 | {5'b00000, code[20:18]};
            r.bytes[1] = CONT | {2'b00, code[17:12]};
            r.bytes[2] = CONT | {2'b00, code[11:6]};
            r.bytes[3] = CONT | {2'b00, code[5:0]};
         end
         return r;
      end
   endfunction

endpackage

@@ design/jsu_decode.sv @@
// Escape decoder: per-string state, capacity register and the single-pass decode of
// one input item into a result group. Depends on jsu_pkg.
module jsu_decode #(
   parameter int MAX_CAPACITY = jsu_pkg::MAX_CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic [12:0]        csr_capacity,
   input  logic               accept,
   input  logic [7:0]         in_byte,
   input  logic               byte_present,
   input  logic               end_of_string,
   output jsu_pkg::group_type group
);

   localparam int CntW = $clog2(MAX_CAPACITY);
   localparam int CapW = (CntW + 1 > 13) ? CntW + 1 : 13;

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_ESC,
      MODE_HEX1,
      MODE_WANT_BS,
      MODE_WANT_U,
      MODE_HEX2,
      MODE_DRAIN
   } mode_type;

   mode_type            mode_ff, mode_in;
   logic [1:0]          hex_cnt_ff, hex_cnt_in;
   logic [15:0]         hex_acc_ff, hex_acc_in;
   logic [9:0]          high_ff, high_in;
   logic [CntW-1:0]     count_ff, count_in;
   jsu_pkg::status_type err_ff, err_in;
   logic [12:0]         capacity_ff;

   logic [CapW-1:0]     cap_eff;
   logic [CapW-1:0]     new_total;
   logic [CapW-1:0]     count_wide;
   logic                emit_req;
   logic                raw;
   logic [20:0]         code;
   logic                fail;
   jsu_pkg::status_type fail_code;
   jsu_pkg::utf8_type   enc;
   logic [4:0]          nib;
   logic [15:0]         acc_next;
   logic                is_zero;

   assign cap_eff = (CapW'(capacity_ff) > CapW'(MAX_CAPACITY)) ?
                    CapW'(MAX_CAPACITY) : CapW'(capacity_ff);
   assign nib      = jsu_pkg::hex_nibble(in_byte);
   assign acc_next = {hex_acc_ff[11:0], nib[3:0]};

   always_comb begin
      mode_in    = mode_ff;
      hex_cnt_in = hex_cnt_ff;
      hex_acc_in = hex_acc_ff;
      high_in    = high_ff;
      count_in   = count_ff;
      err_in     = err_ff;
      emit_req   = 1'b0;
      raw        = 1'b0;
      code       = '0;
      fail       = 1'b0;
      fail_code  = jsu_pkg::STATUS_OK;
      group      = '0;
      enc        = '0;
      is_zero    = 1'b0;
      new_total  = '0;
      count_wide = '0;

      if (byte_present) begin
         unique case (mode_ff)
            MODE_NORMAL: begin
               if (in_byte == jsu_pkg::CHAR_BSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  emit_req = 1'b1;
                  raw      = 1'b1;
               end
            end
            MODE_ESC: begin
               unique case (in_byte)
                  jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BSLASH, jsu_pkg::CHAR_SLASH: begin
                     emit_req = 1'b1;
                     code     = 21'(in_byte);
                  end
                  jsu_pkg::CHAR_B: begin
                     emit_req = 1'b1;
                     code     = 21'(jsu_pkg::CTRL_BS);
                  end
                  jsu_pkg::CHAR_F: begin
                     emit_req = 1'b1;
                     code     = 21'(jsu_pkg::CTRL_FF);
                  end
                  jsu_pkg::CHAR_N: begin
                     emit_req = 1'b1;
                     code     = 21'(jsu_pkg::CTRL_LF);
                  end
                  jsu_pkg::CHAR_R: begin
                     emit_req = 1'b1;
                     code     = 21'(jsu_pkg::CTRL_CR);
                  end
                  jsu_pkg::CHAR_T: begin
                     emit_req = 1'b1;
                     code     = 21'(jsu_pkg::CTRL_TAB);
                  end
                  jsu_pkg::CHAR_U: begin
                     mode_in    = MODE_HEX1;
                     hex_cnt_in = '0;
                     hex_acc_in = '0;
                  end
                  default: begin
                     fail      = 1'b1;
                     fail_code = jsu_pkg::STATUS_BAD_ESCAPE;
                  end
               endcase
            end
            MODE_HEX1, MODE_HEX2: begin
               if (nib[4]) begin
                  fail      = 1'b1;
                  fail_code = jsu_pkg::STATUS_BAD_ESCAPE;
               end else if (hex_cnt_ff != 2'd3) begin
                  hex_acc_in = acc_next;
                  hex_cnt_in = hex_cnt_ff + 2'd1;
               end else begin
                  hex_acc_in = acc_next;
                  hex_cnt_in = '0;
                  if (mode_ff == MODE_HEX1) begin
                     if (acc_next >= jsu_pkg::HIGH_SURR_LO &&
                         acc_next <= jsu_pkg::HIGH_SURR_HI) begin
                        high_in = acc_next[9:0];
                        mode_in = MODE_WANT_BS;
                     end else if (acc_next >= jsu_pkg::LOW_SURR_LO &&
                                  acc_next <= jsu_pkg::LOW_SURR_HI) begin
                        fail      = 1'b1;
                        fail_code = jsu_pkg::STATUS_BAD_SURROGATE;
                     end else begin
                        emit_req = 1'b1;
                        code     = 21'(acc_next);
                     end
                  end else begin
                     if (acc_next < jsu_pkg::LOW_SURR_LO ||
                         acc_next > jsu_pkg::LOW_SURR_HI) begin
                        fail      = 1'b1;
                        fail_code = jsu_pkg::STATUS_BAD_SURROGATE;
                     end else begin
                        // join the pair: the low half's offset is its low ten bits
                        emit_req = 1'b1;
                        code     = jsu_pkg::SUPP_BASE + {1'b0, high_ff, acc_next[9:0]};
                     end
                  end
               end
            end
            MODE_WANT_BS: begin
               if (in_byte != jsu_pkg::CHAR_BSLASH) begin
                  fail      = 1'b1;
                  fail_code = jsu_pkg::STATUS_BAD_SURROGATE;
               end else begin
                  mode_in = MODE_WANT_U;
               end
            end
            MODE_WANT_U: begin
               if (in_byte != jsu_pkg::CHAR_U) begin
                  fail      = 1'b1;
                  fail_code = jsu_pkg::STATUS_BAD_SURROGATE;
               end else begin
                  mode_in    = MODE_HEX2;
                  hex_cnt_in = '0;
                  hex_acc_in = '0;
               end
            end
            MODE_DRAIN: begin
            end
            default: begin
            end
         endcase
      end

      if (emit_req) begin
         if (raw) begin
            enc.len      = 3'd1;
            enc.bytes[0] = in_byte;
            is_zero      = (in_byte == 8'h00);
         end else begin
            enc     = jsu_pkg::utf8_encode(code);
            is_zero = (code == 21'h0);
         end
         new_total = CapW'(count_ff) + CapW'(enc.len);
         if (is_zero) begin
            fail      = 1'b1;
            fail_code = jsu_pkg::STATUS_NUL;
         end else if (new_total >= cap_eff) begin
            fail      = 1'b1;
            fail_code = jsu_pkg::STATUS_TOO_LONG;
         end else begin
            group.bytes  = enc.bytes;
            group.nbytes = enc.len;
            count_in     = new_total[CntW-1:0];
            mode_in      = MODE_NORMAL;
         end
      end

      if (fail) begin
         err_in  = fail_code;
         mode_in = MODE_DRAIN;
      end

      if (end_of_string) begin
         count_wide      = CapW'(count_in);
         group.final_res = 1'b1;
         group.length    = count_wide[11:0];
         priority case (mode_in)
            MODE_DRAIN:   group.status = err_in;
            MODE_NORMAL:  group.status = jsu_pkg::STATUS_OK;
            MODE_WANT_BS: group.status = jsu_pkg::STATUS_BAD_SURROGATE;
            default:      group.status = jsu_pkg::STATUS_TRUNCATED;
         endcase
         // start the next string from clean state
         mode_in    = MODE_NORMAL;
         hex_cnt_in = '0;
         hex_acc_in = '0;
         high_in    = '0;
         count_in   = '0;
         err_in     = jsu_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_NORMAL;
         hex_cnt_ff  <= '0;
         hex_acc_ff  <= '0;
         high_ff     <= '0;
         count_ff    <= '0;
         err_ff      <= jsu_pkg::STATUS_OK;
         capacity_ff <= jsu_pkg::CAPACITY_RESET;
      end else begin
         if (csr_valid) begin
            capacity_ff <= csr_capacity;
         end
         if (accept) begin
            mode_ff    <= mode_in;
            hex_cnt_ff <= hex_cnt_in;
            hex_acc_ff <= hex_acc_in;
            high_ff    <= high_in;
            count_ff   <= count_in;
            err_ff     <= err_in;
         end
      end
   end

endmodule

@@ design/jsu_outbuf.sv @@
// Result register: holds the group of one item and hands it out one result per
// transfer on the rsp channel. Depends on jsu_pkg.
module jsu_outbuf (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  jsu_pkg::group_type group,
   output logic               load_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_data_valid,
   output logic               rsp_final_res,
   output logic [2:0]         rsp_status,
   output logic [11:0]        rsp_out_length
);

   jsu_pkg::group_type group_ff;
   logic [2:0]         pos_ff, pos_in;
   logic [2:0]         total_ff, total_in;
   logic               is_data;

   assign rsp_valid  = (pos_ff != total_ff);
   // take a new group when no result is pending, or while the last result of the current one leaves
   assign load_ready = !rsp_valid || ((pos_ff + 3'd1 == total_ff) && rsp_ready);

   assign is_data        = (pos_ff < group_ff.nbytes);
   assign rsp_out_byte   = is_data ? group_ff.bytes[pos_ff[1:0]] : 8'h00;
   assign rsp_data_valid = is_data;
   assign rsp_final_res  = !is_data;
   assign rsp_status     = is_data ? jsu_pkg::STATUS_OK : group_ff.status;
   assign rsp_out_length = is_data ? 12'd0 : group_ff.length;

   always_comb begin
      pos_in   = pos_ff;
      total_in = total_ff;
      if (load) begin
         pos_in   = '0;
         total_in = group.nbytes + {2'b00, group.final_res};
      end else if (rsp_valid && rsp_ready) begin
         pos_in = pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         total_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         group_ff <= group;
      end
   end

endmodule

@@ design/json_string_unescape_utf8_core.sv @@
// JSON string body unescaper to UTF-8: takes one raw byte per transfer and returns
// decoded bytes followed by one status result per string. Input sustains one item
// per cycle unless rsp stalls or an item yields more than one result; an item that
// yields n results (a four-byte code point plus the closing status gives at most five)
// holds the result register in jsu_outbuf until all transfer; the next item is taken
// in the cycle its predecessor's last result transfers. csr_capacity (buffer size
// including terminator) may be written only while the block is idle; it is clipped to
// MAX_CAPACITY. Depends on jsu_pkg, jsu_decode and jsu_outbuf.
module json_string_unescape_utf8_core #(
   parameter int MAX_CAPACITY = jsu_pkg::MAX_CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_data_valid,
   output logic        rsp_final_res,
   output logic [2:0]  rsp_status,
   output logic [11:0] rsp_out_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_capacity
);

   jsu_pkg::group_type group;
   logic               accept;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   jsu_decode #(
      .MAX_CAPACITY(MAX_CAPACITY)
   ) u_decode (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_capacity  (csr_capacity),
      .accept        (accept),
      .in_byte       (req_in_byte),
      .byte_present  (req_byte_present),
      .end_of_string (req_end_of_string),
      .group         (group)
   );

   jsu_outbuf u_outbuf (
      .clock          (clock),
      .reset          (reset),
      .load           (accept),
      .group          (group),
      .load_ready     (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_data_valid (rsp_data_valid),
      .rsp_final_res  (rsp_final_res),
      .rsp_status     (rsp_status),
      .rsp_out_length (rsp_out_length)
   );

endmodule

@@ design/jsu_checker.sv @@
// Port-level checks for json_string_unescape_utf8_core, attached by bind.
// Sees only the top level's ports.
module jsu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_data_valid,
   input logic        rsp_final_res,
   input logic [2:0]  rsp_status,
   input logic [11:0] rsp_out_length
);

   // a stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_out_byte, rsp_data_valid, rsp_final_res, rsp_status, rsp_out_length}))
      else $error("rsp result changed while stalled");

   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_valid |->
         !rsp_final_res && rsp_status == jsu_pkg::STATUS_OK && rsp_out_length == 12'd0)
      else $error("data result carries status fields");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data_valid |->
         rsp_final_res && rsp_out_byte == 8'h00 && rsp_status <= jsu_pkg::STATUS_TRUNCATED)
      else $error("status result malformed");

   // input stalls only behind a pending result
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_checker (.*);
